>>> src/fht_pkg.sv
// shared types, widths and constants of the homogeneous triangle transform
`default_nettype none
package fht_pkg;

  localparam int unsigned CW    = 32;
  localparam int unsigned AW    = 66;
  localparam int unsigned NREGS = 8;
  localparam int unsigned IDXW  = 4;
  localparam int unsigned RIW   = $clog2(NREGS);

  localparam logic [NREGS-1:0][63:0] CFG_RESET = {
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  localparam logic [CW-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] Q_MIN = 32'h8000_0000;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam int unsigned PROJ_STEPS = 32;
  localparam int unsigned PRW        = AW + PROJ_STEPS;
  localparam int unsigned PROJ_LAT   = PROJ_STEPS + 3;

  localparam int unsigned NORM_PRE   = 9;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned NDIV_STEPS = 31;
  localparam int unsigned NORM_LAT   = NORM_PRE + SQRT_STEPS + NDIV_STEPS + 1;
  localparam int unsigned TOTAL_LAT  = PROJ_LAT + NORM_LAT;

  typedef logic [3:0][3:0][CW-1:0] mat_t;
  typedef logic [2:0][2:0][CW-1:0] tri_t;
  typedef logic [2:0][3:0][AW-1:0] acc_t;

  typedef struct packed {
    logic           empty;
    logic [QCW-1:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

>>> src/fht_front.sv
// front end: accepts triangles and forms the homogeneous matrix products
`default_nettype none
module fht_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  fht_pkg::tri_t    vtx_i,
  input  fht_pkg::mat_t    mat_i,
  input  fht_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output fht_pkg::acc_t    acc_o
);
  import fht_pkg::*;

  logic              v0_q, v1_q, v2_q;
  logic              accept;
  logic [QCW:0]      load;
  tri_t              vtx_q;
  logic signed [63:0] prod_q [3][4][3];
  acc_t              acc_d, acc_q;

  assign load = (QCW+1)'(q_stat_i.count) + (QCW+1)'(v0_q) + (QCW+1)'(v1_q)
              + (QCW+1)'(v2_q);
  assign busy_o = (load >= (QCW+1)'(QDEPTH));
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vtx_q <= vtx_i;
    end
    for (int i = 0; i < 3; i++) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][r][j] <= $signed(mat_i[r][j]) * $signed(vtx_q[i][j]);
        end
      end
    end
    acc_q <= acc_d;
  end

  // column 3 meets w = 1.0, a plain shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int r = 0; r < 4; r++) begin
        acc_d[i][r] = AW'(prod_q[i][r][0]) + AW'(prod_q[i][r][1])
                    + AW'(prod_q[i][r][2]) + AW'($signed({mat_i[r][3], 16'b0}));
      end
    end
  end

  assign push_o = v2_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

>>> src/fht_queue.sv
// short queue between the front end and the back end
`default_nettype none
module fht_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fht_pkg::acc_t    data_i,
  input  logic             pop_i,
  output fht_pkg::acc_t    data_o,
  output fht_pkg::q_stat_t stat_o
);
  import fht_pkg::*;

  acc_t           mem_q [QDEPTH];
  logic [QPW-1:0] wr_q, rd_q;
  logic [QCW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      count_q <= count_q + QCW'(push_i) - QCW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule
`default_nettype wire

>>> src/fht_proj.sv
// pipelined perspective divide of one coordinate by w, saturated to q16.16
`default_nettype none
module fht_proj (
  input  logic                      clk_i,
  input  logic [fht_pkg::AW-1:0]    num_i,
  input  logic [fht_pkg::AW-1:0]    den_i,
  output logic [fht_pkg::CW-1:0]    res_o
);
  import fht_pkg::*;

  typedef struct packed {
    logic nneg;
    logic neg;
    logic ovf;
    logic dzero;
    logic nzero;
  } pflag_t;

  logic [AW-1:0]  nm0_q, dm0_q;
  logic           nneg0_q, neg0_q;
  logic [PRW-1:0] rem_q [PROJ_STEPS+1];
  logic [AW-1:0]  dm_q  [PROJ_STEPS+1];
  logic [CW-1:0]  quo_q [PROJ_STEPS+1];
  pflag_t         fl_q  [PROJ_STEPS+1];
  logic [PRW-1:0] rem_init;
  logic [CW-1:0]  qf;
  pflag_t         ff;
  logic [CW-1:0]  res_d, res_q;

  always_ff @(posedge clk_i) begin
    nneg0_q <= num_i[AW-1];
    neg0_q  <= num_i[AW-1] ^ den_i[AW-1];
    nm0_q   <= num_i[AW-1] ? (AW'(0) - num_i) : num_i;
    dm0_q   <= den_i[AW-1] ? (AW'(0) - den_i) : den_i;
  end

  assign rem_init = PRW'({nm0_q, 16'b0});

  always_ff @(posedge clk_i) begin
    rem_q[0]       <= rem_init;
    dm_q[0]        <= dm0_q;
    quo_q[0]       <= '0;
    fl_q[0].nneg   <= nneg0_q;
    fl_q[0].neg    <= neg0_q;
    fl_q[0].ovf    <= (rem_init >= PRW'({dm0_q, 32'b0}));
    fl_q[0].dzero  <= (dm0_q == '0);
    fl_q[0].nzero  <= (nm0_q == '0);
  end

  for (genvar k = 0; k < PROJ_STEPS; k++) begin : g_step
    localparam int unsigned SH = PROJ_STEPS - 1 - k;
    logic [PRW-1:0] trial;
    assign trial = PRW'(dm_q[k]) << SH;
    always_ff @(posedge clk_i) begin
      dm_q[k+1] <= dm_q[k];
      fl_q[k+1] <= fl_q[k];
      if (rem_q[k] >= trial) begin
        rem_q[k+1] <= rem_q[k] - trial;
        quo_q[k+1] <= {quo_q[k][CW-2:0], 1'b1};
      end else begin
        rem_q[k+1] <= rem_q[k];
        quo_q[k+1] <= {quo_q[k][CW-2:0], 1'b0};
      end
    end
  end

  assign qf = quo_q[PROJ_STEPS];
  assign ff = fl_q[PROJ_STEPS];

  always_comb begin
    if (ff.dzero) begin
      res_d = ff.nzero ? '0 : (ff.nneg ? Q_MIN : Q_MAX);
    end else if (ff.neg) begin
      res_d = (ff.ovf || qf > Q_MIN) ? Q_MIN : (CW'(0) - qf);
    end else begin
      res_d = (ff.ovf || qf > Q_MAX) ? Q_MAX : qf;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

>>> src/fht_normal.sv
// pipelined unit face normal: cross product, normalize, square root, divide
`default_nettype none
module fht_normal (
  input  logic                         clk_i,
  input  fht_pkg::tri_t                v_i,
  output logic [2:0][fht_pkg::CW-1:0]  nrm_o
);
  import fht_pkg::*;

  logic signed [32:0] u_q [3];
  logic signed [32:0] w_q [3];
  logic signed [65:0] pr_q [3][2];
  logic signed [66:0] cr_q [3];
  logic [66:0]        mag3_q [3], mag4_q [3], mag5_q [3];
  logic [2:0]         sg3_q, sg4_q, sg5_q, sg6_q, sg7_q;
  logic [66:0]        mx_d, mx_q;
  logic [6:0]         len_d, len_q;
  logic [2:0][30:0]   c6_q, c7_q;
  logic               zr6_q, zr7_q;
  logic [61:0]        sq_q [3];
  logic [63:0]        sn_q [SQRT_STEPS+1];
  logic [63:0]        sr_q [SQRT_STEPS+1];
  logic [2:0][30:0]   ca_q [SQRT_STEPS+1];
  logic [2:0]         sga_q [SQRT_STEPS+1];
  logic               zra_q [SQRT_STEPS+1];
  logic [63:0]        drem [NDIV_STEPS+1][3];
  logic [NDIV_STEPS-1:0] dquo [NDIV_STEPS+1][3];
  logic [31:0]        droot [NDIV_STEPS+1];
  logic [2:0]         dsg [NDIV_STEPS+1];
  logic               dzr [NDIV_STEPS+1];
  logic [2:0][CW-1:0] nrm_q;

  for (genvar j = 0; j < 3; j++) begin : g_cross
    localparam int unsigned A = (j + 1) % 3;
    localparam int unsigned B = (j + 2) % 3;
    always_ff @(posedge clk_i) begin
      u_q[j]     <= 33'($signed(v_i[1][j])) - 33'($signed(v_i[0][j]));
      w_q[j]     <= 33'($signed(v_i[2][j])) - 33'($signed(v_i[0][j]));
      pr_q[j][0] <= u_q[A] * w_q[B];
      pr_q[j][1] <= u_q[B] * w_q[A];
      cr_q[j]    <= 67'(pr_q[j][0]) - 67'(pr_q[j][1]);
      mag3_q[j]  <= cr_q[j][66] ? 67'(-cr_q[j]) : 67'(cr_q[j]);
      sg3_q[j]   <= cr_q[j][66];
      mag4_q[j]  <= mag3_q[j];
      mag5_q[j]  <= mag4_q[j];
    end
  end

  always_comb begin
    mx_d = (mag3_q[1] >= mag3_q[0]) ? mag3_q[1] : mag3_q[0];
    if (mag3_q[2] >= mx_d) begin
      mx_d = mag3_q[2];
    end
  end

  always_comb begin
    len_d = '0;
    for (int b = 0; b < 67; b++) begin
      if (mx_q[b]) begin
        len_d = 7'(b + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q  <= mx_d;
    sg4_q <= sg3_q;
    len_q <= len_d;
    sg5_q <= sg4_q;
    for (int j = 0; j < 3; j++) begin
      c6_q[j] <= 31'(({mag5_q[j], 31'b0}) >> len_q);
      sq_q[j] <= c6_q[j] * c6_q[j];
    end
    zr6_q <= (len_q == '0);
    sg6_q <= sg5_q;
    c7_q  <= c6_q;
    zr7_q <= zr6_q;
    sg7_q <= sg6_q;
    sn_q[0]  <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    sr_q[0]  <= '0;
    ca_q[0]  <= c7_q;
    zra_q[0] <= zr7_q;
    sga_q[0] <= sg7_q;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sr_q[k] + BITV;
    always_ff @(posedge clk_i) begin
      ca_q[k+1]  <= ca_q[k];
      sga_q[k+1] <= sga_q[k];
      zra_q[k+1] <= zra_q[k];
      if (sn_q[k] >= trial) begin
        sn_q[k+1] <= sn_q[k] - trial;
        sr_q[k+1] <= (sr_q[k] >> 1) + BITV;
      end else begin
        sn_q[k+1] <= sn_q[k];
        sr_q[k+1] <= sr_q[k] >> 1;
      end
    end
  end

  always_comb begin
    droot[0] = sr_q[SQRT_STEPS][31:0];
    dsg[0]   = sga_q[SQRT_STEPS];
    dzr[0]   = zra_q[SQRT_STEPS];
    for (int j = 0; j < 3; j++) begin
      drem[0][j] = 64'({ca_q[SQRT_STEPS][j], 30'b0});
      dquo[0][j] = '0;
    end
  end

  for (genvar k = 0; k < NDIV_STEPS; k++) begin : g_div
    localparam int unsigned SH = NDIV_STEPS - 1 - k;
    logic [63:0] trial;
    assign trial = 64'(droot[k]) << SH;
    always_ff @(posedge clk_i) begin
      droot[k+1] <= droot[k];
      dsg[k+1]   <= dsg[k];
      dzr[k+1]   <= dzr[k];
      for (int j = 0; j < 3; j++) begin
        if (drem[k][j] >= trial) begin
          drem[k+1][j] <= drem[k][j] - trial;
          dquo[k+1][j] <= {dquo[k][j][NDIV_STEPS-2:0], 1'b1};
        end else begin
          drem[k+1][j] <= drem[k][j];
          dquo[k+1][j] <= {dquo[k][j][NDIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (dzr[NDIV_STEPS]) begin
        nrm_q[j] <= '0;
      end else if (dsg[NDIV_STEPS][j]) begin
        nrm_q[j] <= CW'(0) - CW'(dquo[NDIV_STEPS][j]);
      end else begin
        nrm_q[j] <= CW'(dquo[NDIV_STEPS][j]);
      end
    end
  end

  assign nrm_o = nrm_q;

endmodule
`default_nettype wire

>>> src/facet_homogeneous_transform.sv
// top level: 4x4 homogeneous transform of a triangle with unit face normal
//
//   channel   signals                                        direction
//   command   start, busy, in_{a,b,c}_{x,y,z}_i              in, busy out
//   result    done_o, out_{a,b,c}_{x,y,z}_o, unit_normal_*_o out
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i in, cfg_ready_o out
//
// one triangle per cycle; done_o for a command rises once the command has passed through
// 3 front stages, the queue write, the 35-stage divide by w and the 73-stage normal path
// the front stalls only if the queue could fill, which never happens in use
// results are one-cycle strobes on done_o; reset clears all control state
`default_nettype none
module facet_homogeneous_transform (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         in_a_x_i,
  input  logic signed [31:0]         in_a_y_i,
  input  logic signed [31:0]         in_a_z_i,
  input  logic signed [31:0]         in_b_x_i,
  input  logic signed [31:0]         in_b_y_i,
  input  logic signed [31:0]         in_b_z_i,
  input  logic signed [31:0]         in_c_x_i,
  input  logic signed [31:0]         in_c_y_i,
  input  logic signed [31:0]         in_c_z_i,
  output logic                       done_o,
  output logic signed [31:0]         out_a_x_o,
  output logic signed [31:0]         out_a_y_o,
  output logic signed [31:0]         out_a_z_o,
  output logic signed [31:0]         out_b_x_o,
  output logic signed [31:0]         out_b_y_o,
  output logic signed [31:0]         out_b_z_o,
  output logic signed [31:0]         out_c_x_o,
  output logic signed [31:0]         out_c_y_o,
  output logic signed [31:0]         out_c_z_o,
  output logic signed [31:0]         unit_normal_x_o,
  output logic signed [31:0]         unit_normal_y_o,
  output logic signed [31:0]         unit_normal_z_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [fht_pkg::IDXW-1:0]   cfg_index_i,
  input  logic [63:0]                cfg_data_i
);
  import fht_pkg::*;

  logic [NREGS-1:0][63:0] cfg_q;
  mat_t                   mat;
  tri_t                   vtx;
  tri_t                   pv;
  tri_t                   vd_q [NORM_LAT];
  logic                   push, pop;
  acc_t                   acc_f, acc_b;
  q_stat_t                q_stat;
  logic [TOTAL_LAT-1:0]   vld_q;
  logic [2:0][CW-1:0]     nrm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o && cfg_index_i < IDXW'(NREGS)) begin
      cfg_q[cfg_index_i[RIW-1:0]] <= cfg_data_i;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign mat[r][c] = cfg_q[2 * r + c / 2][(c % 2) * CW +: CW];
    end
  end

  assign vtx[0][0] = in_a_x_i;
  assign vtx[0][1] = in_a_y_i;
  assign vtx[0][2] = in_a_z_i;
  assign vtx[1][0] = in_b_x_i;
  assign vtx[1][1] = in_b_y_i;
  assign vtx[1][2] = in_b_z_i;
  assign vtx[2][0] = in_c_x_i;
  assign vtx[2][1] = in_c_y_i;
  assign vtx[2][2] = in_c_z_i;

  fht_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .vtx_i    (vtx),
    .mat_i    (mat),
    .q_stat_i (q_stat),
    .push_o   (push),
    .acc_o    (acc_f)
  );

  fht_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (acc_f),
    .pop_i  (pop),
    .data_o (acc_b),
    .stat_o (q_stat)
  );

  assign pop = !q_stat.empty;

  for (genvar i = 0; i < 3; i++) begin : g_vtx
    for (genvar j = 0; j < 3; j++) begin : g_crd
      fht_proj u_proj (
        .clk_i (clk_i),
        .num_i (acc_b[i][j]),
        .den_i (acc_b[i][3]),
        .res_o (pv[i][j])
      );
    end
  end

  fht_normal u_normal (
    .clk_i (clk_i),
    .v_i   (pv),
    .nrm_o (nrm)
  );

  always_ff @(posedge clk_i) begin
    vd_q[0] <= pv;
    for (int k = 1; k < NORM_LAT; k++) begin
      vd_q[k] <= vd_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOTAL_LAT-2:0], pop};
    end
  end

  assign done_o          = vld_q[TOTAL_LAT-1];
  assign out_a_x_o       = vd_q[NORM_LAT-1][0][0];
  assign out_a_y_o       = vd_q[NORM_LAT-1][0][1];
  assign out_a_z_o       = vd_q[NORM_LAT-1][0][2];
  assign out_b_x_o       = vd_q[NORM_LAT-1][1][0];
  assign out_b_y_o       = vd_q[NORM_LAT-1][1][1];
  assign out_b_z_o       = vd_q[NORM_LAT-1][1][2];
  assign out_c_x_o       = vd_q[NORM_LAT-1][2][0];
  assign out_c_y_o       = vd_q[NORM_LAT-1][2][1];
  assign out_c_z_o       = vd_q[NORM_LAT-1][2][2];
  assign unit_normal_x_o = nrm[0];
  assign unit_normal_y_o = nrm[1];
  assign unit_normal_z_o = nrm[2];

`ifndef NO_ASSERTIONS
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_stat.count < QCW'(QDEPTH)) || pop)
    else $error("queue overflow");

  a_flat_normal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_a_x_o == out_b_x_o && out_a_x_o == out_c_x_o
    && out_a_y_o == out_b_y_o && out_a_y_o == out_c_y_o
    && out_a_z_o == out_b_z_o && out_a_z_o == out_c_z_o
    |-> unit_normal_x_o == '0 && unit_normal_y_o == '0 && unit_normal_z_o == '0)
    else $error("degenerate triangle gave a nonzero normal");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> unit_normal_x_o <= 32'sh4000_0000 && unit_normal_x_o >= -32'sh4000_0000
    && unit_normal_y_o <= 32'sh4000_0000 && unit_normal_y_o >= -32'sh4000_0000
    && unit_normal_z_o <= 32'sh4000_0000 && unit_normal_z_o >= -32'sh4000_0000)
    else $error("normal component out of range");
`endif

endmodule
`default_nettype wire

>>> dv/tb_facet_homogeneous_transform.sv
// testbench for the homogeneous triangle transform: directed and random triangles vs predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_facet_homogeneous_transform;
  import fht_pkg::*;

  typedef logic [8:0][31:0]  tri_in_t;
  typedef logic [11:0][31:0] tri_out_t;

  localparam logic [3:0] REG_ROW0_C01 = 4'd0;
  localparam logic [3:0] REG_ROW0_C23 = 4'd1;
  localparam logic [3:0] REG_ROW1_C01 = 4'd2;
  localparam logic [3:0] REG_ROW1_C23 = 4'd3;
  localparam logic [3:0] REG_ROW2_C01 = 4'd4;
  localparam logic [3:0] REG_ROW2_C23 = 4'd5;
  localparam logic [3:0] REG_ROW3_C01 = 4'd6;
  localparam logic [3:0] REG_ROW3_C23 = 4'd7;
  localparam logic [3:0] REG_BAD_IDX  = 4'd11;
  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  tri_in_t drv_tri = '0;
  logic done_o;
  tri_out_t got;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IDXW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  logic [NREGS-1:0][63:0] matrix_regs = CFG_RESET;
  tri_out_t expected_results[$];
  int unsigned error_count = 0;

  always #4 clk_i = ~clk_i;

  facet_homogeneous_transform DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_a_x_i(drv_tri[0]), .in_a_y_i(drv_tri[1]), .in_a_z_i(drv_tri[2]),
    .in_b_x_i(drv_tri[3]), .in_b_y_i(drv_tri[4]), .in_b_z_i(drv_tri[5]),
    .in_c_x_i(drv_tri[6]), .in_c_y_i(drv_tri[7]), .in_c_z_i(drv_tri[8]),
    .done_o(done_o),
    .out_a_x_o(got[0]), .out_a_y_o(got[1]), .out_a_z_o(got[2]),
    .out_b_x_o(got[3]), .out_b_y_o(got[4]), .out_b_z_o(got[5]),
    .out_c_x_o(got[6]), .out_c_y_o(got[7]), .out_c_z_o(got[8]),
    .unit_normal_x_o(got[9]), .unit_normal_y_o(got[10]), .unit_normal_z_o(got[11]),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  function automatic tri_out_t transform_triangle(input tri_in_t t);
    tri_out_t res;
    logic signed [127:0] acc[4];
    logic signed [127:0] vert[3][3];
    logic signed [127:0] ent, pt, u[3], w[3], cr[3];
    logic [127:0] nm, dm, q, mag[3], mx, sh;
    logic [63:0] cc[3], ssum, rem, root, bitv, nq;
    logic nneg, neg;
    int len;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      for (int r = 0; r < 4; r++) begin
        acc[r] = 0;
        for (int j = 0; j < 4; j++) begin
          ent = $signed(matrix_regs[2*r + j/2][(j%2)*32 +: 32]);
          pt = (j == 3) ? $signed({1'b0, ONE_Q16}) : $signed(t[3*i + j]);
          acc[r] = acc[r] + ent * pt;
        end
      end
      for (int j = 0; j < 3; j++) begin
        nneg = acc[j] < 0;
        neg = nneg != (acc[3] < 0);
        nm = nneg ? -acc[j] : acc[j];
        dm = (acc[3] < 0) ? -acc[3] : acc[3];
        if (dm == 0) begin
          vert[i][j] = (nm == 0) ? 0 : (nneg ? -128'sd2147483648 : 128'sd2147483647);
        end else begin
          q = (nm << 16) / dm;
          if (neg) vert[i][j] = (q > 128'h8000_0000) ? -128'sd2147483648 : -$signed(q);
          else vert[i][j] = (q > 128'h7fff_ffff) ? 128'sd2147483647 : $signed(q);
        end
        res[3*i + j] = vert[i][j][31:0];
      end
    end
    for (int j = 0; j < 3; j++) begin
      u[j] = vert[1][j] - vert[0][j];
      w[j] = vert[2][j] - vert[0][j];
    end
    cr[0] = u[1] * w[2] - u[2] * w[1];
    cr[1] = u[2] * w[0] - u[0] * w[2];
    cr[2] = u[0] * w[1] - u[1] * w[0];
    mx = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = (cr[j] < 0) ? -cr[j] : cr[j];
      if (mag[j] >= mx) mx = mag[j];
    end
    len = 0;
    for (int b = 0; b < 128; b++) if (mx[b]) len = b + 1;
    if (len == 0) return res;
    ssum = 0;
    for (int j = 0; j < 3; j++) begin
      sh = (len > 31) ? (mag[j] >> (len - 31)) : (mag[j] << (31 - len));
      cc[j] = sh[63:0];
      ssum = ssum + cc[j] * cc[j];
    end
    // integer square root, bit by bit
    rem = ssum;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    for (int j = 0; j < 3; j++) begin
      nq = (cc[j] << 30) / root;
      res[9 + j] = (cr[j] < 0) ? -nq[31:0] : nq[31:0];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        tri_out_t exp_r;
        exp_r = expected_results.pop_front();
        for (int f = 0; f < 12; f++) begin
          if (exp_r[f] !== got[f]) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch field %0d: expected %h actual %h", f, exp_r[f], got[f]);
          end
        end
      end
    end
  end

  task automatic send_triangle(input tri_in_t t);
    @(negedge clk_i);
    start <= 1'b1;
    drv_tri <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results = {expected_results, transform_triangle(t)};
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 :
        (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < NREGS) matrix_regs[idx] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_matrix(input logic [3:0][3:0][31:0] m);
    for (int r = 0; r < 4; r++) begin
      write_reg(4'(2*r), {m[r][1], m[r][0]});
      write_reg(4'(2*r + 1), {m[r][3], m[r][2]});
    end
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2*(64 << 16))) - (64 << 16));
      2: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2*(4 << 16))) - (4 << 16));
    endcase
  endfunction

  function automatic tri_in_t rand_triangle();
    tri_in_t t;
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++)
      t[k] = (mode < 3) ? rand_coord(0) :
             (mode < 8) ? rand_coord(1) : rand_coord($urandom_range(0, 3));
    // collinear or repeated vertices now and then
    if ($urandom_range(0, 15) == 0) for (int k = 0; k < 3; k++) t[6 + k] = t[k];
    return t;
  endfunction

  task automatic test_identity_directed();
    tri_in_t t;
    send_triangle('0);
    t = '0;
    t[3] = ONE_Q16; t[7] = ONE_Q16;
    send_triangle(t);
    idle_gap();
    send_triangle({9{32'h7fff_ffff}});
    send_triangle({9{32'h8000_0000}});
    t = {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
         32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    send_triangle(t);
    t = {32'h3_0000, 32'h3_0000, 32'h3_0000, 32'h2_0000, 32'h2_0000, 32'h2_0000,
         32'h1_0000, 32'h1_0000, 32'h1_0000};
    send_triangle(t);
    send_triangle({32'h0, 32'h0, 32'h1, 32'h0, 32'h1, 32'h0, 32'h1, 32'h0, 32'h0});
    send_triangle({32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0,
                   32'h0, 32'h0, 32'hffff_ffff});
    drain();
  endtask

  task automatic test_zero_and_negative_w();
    logic [3:0][3:0][31:0] m;
    tri_in_t t;
    m = '0;
    m[0][0] = ONE_Q16; m[1][1] = ONE_Q16; m[2][2] = ONE_Q16;
    load_matrix(m);
    t = {32'h0, 32'h0, 32'h0, 32'hfffe_0000, 32'h0, 32'h2_0000,
         32'h0, 32'hffff_0000, 32'h1_0000};
    send_triangle(t);
    send_triangle('0);
    drain();
    m[3][3] = 32'hffff_0000;
    write_reg(REG_ROW3_C23, {m[3][3], m[3][2]});
    send_triangle(t);
    drain();
    m[3][3] = 32'h0000_0001;
    write_reg(REG_ROW3_C23, {m[3][3], m[3][2]});
    send_triangle(t);
    send_triangle({32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h1, 32'hffff_ffff, 32'h0,
                   32'h0, 32'h5, 32'hffff_fffb});
    drain();
  endtask

  task automatic test_extreme_matrices();
    send_triangle({9{32'h0001_2345}});
    drain();
    for (int r = 0; r < NREGS; r++) write_reg(4'(r), 64'h7fff_ffff_7fff_ffff);
    send_triangle({9{32'h7fff_ffff}});
    send_triangle({32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0});
    drain();
    for (int r = 0; r < NREGS; r++) write_reg(4'(r), 64'h8000_0000_8000_0000);
    send_triangle({9{32'h8000_0000}});
    send_triangle({32'h7fff_ffff, 32'h0, 32'h1, 32'h0, 32'h8000_0000, 32'h1,
                   32'h1, 32'h1, 32'h0});
    drain();
  endtask

  task automatic test_ignored_index();
    load_matrix({32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000});
    write_reg(REG_BAD_IDX, 64'hdead_beef_dead_beef);
    write_reg(4'hf, '1);
    send_triangle({32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h5_0000,
                   32'h6_0000, 32'h7_0000, 32'h8_0001, 32'h9_0000});
    drain();
  endtask

  task automatic test_random_phases();
    logic [3:0][3:0][31:0] m;
    int kind;
    for (int ph = 0; ph < 6; ph++) begin
      kind = ph % 3;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          if (kind == 0) m[r][c] = $urandom();
          else if (kind == 1) m[r][c] = rand_coord(3);
          else m[r][c] = (r == c) ? $signed(32'($urandom_range(1 << 14, 4 << 16)))
                                  : ($signed(rand_coord(3)) >>> 4);
        end
      if (kind == 1 && $urandom_range(0, 1) != 0) m[3] = '0;
      load_matrix(m);
      for (int k = 0; k < 210; k++) begin
        send_triangle(rand_triangle());
        idle_gap();
      end
      drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_identity_directed();
    test_zero_and_negative_w();
    test_extreme_matrices();
    test_ignored_index();
    test_random_phases();
    repeat (TOTAL_LAT + 20) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
